/* rtl/bme_pkg.sv */
// Package for the block-match obfuscating encoder.
// Types, constants and small helper functions shared by bme_table, bme_emit and the top level.
// No dependencies.
`default_nettype none

package bme_pkg;

	localparam int unsigned TableEntries = 256;
	localparam int unsigned IdxW         = $clog2(TableEntries);
	localparam int unsigned BlockBytes   = 8;

	typedef logic [7:0]            byte_t;
	typedef logic [IdxW-1:0]       idx_t;
	typedef logic [8*BlockBytes-1:0] word_t;
	typedef logic [3:0]            cnt_t;

	localparam byte_t       KEY_START_RST = 8'd87;
	localparam byte_t       OBF_CONST     = 8'hB9;
	localparam byte_t       SECRET_CONST  = 8'h53;
	localparam logic [31:0] COUNT_CONST   = 32'h5455_5657;
	localparam cnt_t        FULL_BLOCK    = 4'd8;
	localparam idx_t        LAST_ENTRY    = idx_t'(TableEntries - 1);

	typedef struct packed {
		logic re;
		idx_t addr;
	} tbl_rd_t;

	typedef struct packed {
		logic  we;
		idx_t  addr;
		word_t data;
	} tbl_wr_t;

	typedef struct packed {
		logic  req;
		byte_t value;
		logic  last;
	} emit_req_t;

	function automatic byte_t bitrev8(input byte_t v);
		byte_t r;
		for (int k = 0; k < 8; k++) begin
			r[7-k] = v[k];
		end
		return r;
	endfunction

	// bit k set for every lane below n
	function automatic byte_t lane_mask(input cnt_t n);
		byte_t m;
		for (int k = 0; k < 8; k++) begin
			m[k] = (4'(k) < n);
		end
		return m;
	endfunction

	function automatic cnt_t popcount8(input byte_t v);
		cnt_t c;
		c = '0;
		for (int k = 0; k < 8; k++) begin
			c = c + cnt_t'(v[k]);
		end
		return c;
	endfunction

	function automatic logic [2:0] lowest_bit(input byte_t v);
		logic [2:0] r;
		r = '0;
		for (int k = 7; k >= 0; k--) begin
			if (v[k]) begin
				r = 3'(k);
			end
		end
		return r;
	endfunction

endpackage

`default_nettype wire

/* rtl/bme_table.sv */
// Block table: 256 x 64-bit synchronous memory, one read and one write port.
// Per-entry valid flags give the reset contents (entry i = byte i eight times).
// Depends on bme_pkg.
`default_nettype none

module bme_table
	import bme_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire tbl_rd_t rd,
	input  wire tbl_wr_t wr,
	input  wire logic    clr,
	output word_t        rd_data
);

	word_t                   mem_q [TableEntries];
	logic [TableEntries-1:0] valid_q;
	word_t                   data_s1;
	idx_t                    idx_s1;
	logic                    hit_s1;

	always_ff @(posedge clk) begin
		if (wr.we) begin
			mem_q[wr.addr] <= wr.data;
		end
		if (rd.re) begin
			data_s1 <= mem_q[rd.addr];
			idx_s1  <= rd.addr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			hit_s1  <= 1'b0;
		end else begin
			if (rd.re) begin
				hit_s1 <= valid_q[rd.addr];
			end
			if (clr) begin
				valid_q <= '0;
			end else if (wr.we) begin
				valid_q[wr.addr] <= 1'b1;
			end
		end
	end

	assign rd_data = hit_s1 ? data_s1 : {BlockBytes{idx_s1}};

endmodule

`default_nettype wire

/* rtl/bme_emit.sv */
// Output stage: obfuscates each byte with the key counter, keeps the plain sum
// and holds the result item in a register until it is taken.
// Depends on bme_pkg.
`default_nettype none

module bme_emit
	import bme_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire emit_req_t   req,
	input  wire byte_t       key_start,
	input  wire logic [31:0] byte_count,
	output logic             ready,
	output logic             result_valid,
	input  wire logic        result_stall,
	output byte_t            out_byte,
	output logic             out_last,
	output byte_t            header_secret,
	output logic [31:0]      header_count
);

	logic  valid_q;
	byte_t key_q;
	byte_t sum_q;
	byte_t sum_next;
	logic  fire;

	assign ready    = !valid_q || !result_stall;
	assign fire     = req.req && ready;
	assign sum_next = sum_q + req.value;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			key_q   <= KEY_START_RST;
			sum_q   <= '0;
		end else begin
			if (ready) begin
				valid_q <= req.req;
			end
			if (fire) begin
				// restart the key and sum after the final byte of a stream
				if (req.last) begin
					key_q <= key_start;
					sum_q <= '0;
				end else begin
					key_q <= key_q + 8'd1;
					sum_q <= sum_next;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_byte      <= req.value ^ bitrev8(key_q) ^ OBF_CONST;
			out_last      <= req.last;
			header_secret <= req.last ? (sum_next ^ SECRET_CONST) : '0;
			header_count  <= req.last ? (byte_count ^ COUNT_CONST) : '0;
		end
	end

	assign result_valid = valid_q;

endmodule

`default_nettype wire

/* rtl/block_match_obfuscating_encoder.sv */
// Top level of the block-match obfuscating encoder: byte intake, block buffer,
// table search sequencer and block coding. Uses bme_table and bme_emit.
// Depends on bme_pkg.
//
// channel   | handshake                 | payload
// ----------+---------------------------+----------------------------------------
// input     | data_valid / data_stall   | data_byte, is_last
// result    | result_valid / result_stall | out_byte, out_last, header_secret,
//           |                           | header_count
// config    | cfg_we                    | cfg_wdata (key_start)
//
// A byte that does not close a block is taken with the encoder staying idle.
// A closing byte starts a table search of one entry per cycle through the memory
// read port, until a full match or the last entry, then the block is coded.
// A final full block adds a second search that ends at entry 0.
// Reset restores the table through per-entry valid flags; no clearing pass.
// A stalled result holds in the output register; coding waits on it.
`default_nettype none

module block_match_obfuscating_encoder
	import bme_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        data_valid,
	output logic             data_stall,
	input  wire logic [7:0]  data_byte,
	input  wire logic        is_last,
	output logic             result_valid,
	input  wire logic        result_stall,
	output logic [7:0]       out_byte,
	output logic             out_last,
	output logic [7:0]       header_secret,
	output logic [31:0]      header_count,
	input  wire logic        cfg_we,
	input  wire logic [7:0]  cfg_wdata
);

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_SEARCH = 6'b000010,
		S_INDEX  = 6'b000100,
		S_MASK   = 6'b001000,
		S_DATA   = 6'b010000,
		S_LEN    = 6'b100000
	} state_t;

	state_t      state_q;
	cnt_t        fill_q;
	byte_t       blk_q [BlockBytes];
	logic [31:0] byte_count_q;
	byte_t       key_start_q;
	cnt_t        n_q;
	logic        last_pend_q;
	idx_t        e_q;
	logic        issue_done_q;
	logic        cmp_v_s1;
	idx_t        cmp_idx_s1;
	logic        have_best_q;
	cnt_t        best_q;
	idx_t        pos_q;
	byte_t       mask_q;
	byte_t       rem_q;

	tbl_rd_t   rd;
	tbl_wr_t   wr;
	logic      clr;
	word_t     rd_data;
	emit_req_t req;
	logic      emit_ready;
	logic      accept;
	byte_t     eq;
	byte_t     lanes;
	byte_t     cand;
	cnt_t      m;
	logic      better;
	logic      full;

	assign data_stall = (state_q != S_IDLE);
	assign accept     = data_valid && !data_stall;

	always_comb begin
		for (int k = 0; k < BlockBytes; k++) begin
			eq[k] = (blk_q[k] == rd_data[8*k +: 8]);
		end
	end

	assign lanes  = lane_mask(n_q);
	assign cand   = ~eq & lanes;
	assign m      = popcount8(eq & lanes);
	assign better = !have_best_q || (m > best_q);
	assign full   = (m == n_q);

	always_comb begin
		rd.re   = (state_q == S_SEARCH) && !issue_done_q;
		rd.addr = e_q;
		wr.we   = (state_q == S_DATA) && (rem_q == '0) && (n_q == FULL_BLOCK);
		wr.addr = pos_q;
		for (int k = 0; k < BlockBytes; k++) begin
			wr.data[8*k +: 8] = blk_q[k];
		end
		clr = (state_q == S_LEN) && emit_ready;
	end

	always_comb begin
		req = '0;
		unique case (state_q)
			S_INDEX: begin
				req.req   = 1'b1;
				req.value = pos_q;
			end
			S_MASK: begin
				req.req   = 1'b1;
				req.value = mask_q;
			end
			S_DATA: begin
				req.req   = (rem_q != '0);
				req.value = blk_q[lowest_bit(rem_q)];
			end
			S_LEN: begin
				req.req   = 1'b1;
				req.value = {4'b0000, n_q};
				req.last  = 1'b1;
			end
			default: begin
				req = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			blk_q[fill_q[2:0]] <= data_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_start_q <= KEY_START_RST;
		end else if (cfg_we) begin
			key_start_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmp_v_s1   <= 1'b0;
			cmp_idx_s1 <= '0;
		end else begin
			cmp_v_s1 <= rd.re;
			if (rd.re) begin
				cmp_idx_s1 <= e_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			fill_q       <= '0;
			byte_count_q <= '0;
			n_q          <= '0;
			last_pend_q  <= 1'b0;
			e_q          <= '0;
			issue_done_q <= 1'b0;
			have_best_q  <= 1'b0;
			best_q       <= '0;
			pos_q        <= '0;
			mask_q       <= '0;
			rem_q        <= '0;
		end else begin
			if (state_q != S_SEARCH) begin
				e_q          <= '0;
				issue_done_q <= 1'b0;
				have_best_q  <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						byte_count_q <= byte_count_q + 32'd1;
						if (fill_q == FULL_BLOCK - 4'd1) begin
							n_q         <= FULL_BLOCK;
							last_pend_q <= is_last;
							fill_q      <= '0;
							state_q     <= S_SEARCH;
						end else if (is_last) begin
							n_q         <= fill_q + 4'd1;
							last_pend_q <= 1'b0;
							fill_q      <= '0;
							state_q     <= S_SEARCH;
						end else begin
							fill_q <= fill_q + 4'd1;
						end
					end
				end
				S_SEARCH: begin
					if (!issue_done_q) begin
						e_q          <= e_q + idx_t'(1);
						issue_done_q <= (e_q == LAST_ENTRY);
					end
					if (cmp_v_s1) begin
						if (better) begin
							have_best_q <= 1'b1;
							best_q      <= m;
							pos_q       <= cmp_idx_s1;
							mask_q      <= cand;
						end
						// stop on a full match or after the last entry
						if (full || (cmp_idx_s1 == LAST_ENTRY)) begin
							state_q <= S_INDEX;
						end
					end
				end
				S_INDEX: begin
					if (emit_ready) begin
						state_q <= S_MASK;
					end
				end
				S_MASK: begin
					if (emit_ready) begin
						rem_q   <= mask_q;
						state_q <= S_DATA;
					end
				end
				S_DATA: begin
					if (rem_q != '0) begin
						if (emit_ready) begin
							rem_q <= rem_q & (rem_q - 8'd1);
						end
					end else if (n_q == FULL_BLOCK) begin
						if (last_pend_q) begin
							n_q         <= '0;
							last_pend_q <= 1'b0;
							state_q     <= S_SEARCH;
						end else begin
							state_q <= S_IDLE;
						end
					end else begin
						state_q <= S_LEN;
					end
				end
				S_LEN: begin
					if (emit_ready) begin
						byte_count_q <= '0;
						fill_q       <= '0;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	bme_table u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd      (rd),
		.wr      (wr),
		.clr     (clr),
		.rd_data (rd_data)
	);

	bme_emit u_emit (
		.clk           (clk),
		.arst_n        (arst_n),
		.req           (req),
		.key_start     (key_start_q),
		.byte_count    (byte_count_q),
		.ready         (emit_ready),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.out_byte      (out_byte),
		.out_last      (out_last),
		.header_secret (header_secret),
		.header_count  (header_count)
	);

endmodule

`default_nettype wire

/* rtl/bme_checker.sv */
// Port-level checks for the block-match obfuscating encoder, bound to the top.
// Depends on block_match_obfuscating_encoder.
`default_nettype none

module bme_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        data_valid,
	input wire logic        data_stall,
	input wire logic        is_last,
	input wire logic        result_valid,
	input wire logic        result_stall,
	input wire logic [7:0]  out_byte,
	input wire logic        out_last,
	input wire logic [7:0]  header_secret,
	input wire logic [31:0] header_count
);

	// hold a stalled result item
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(out_byte) && $stable(out_last))
		else $error("stalled result item changed");

	// header fields only on the final byte
	a_header_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !out_last |-> header_secret == 8'd0 && header_count == 32'd0)
		else $error("header fields set on a non-final byte");

	// the last byte always starts a block search
	a_last_busy: assert property (@(posedge clk) disable iff (!arst_n)
		data_valid && !data_stall && is_last |=> data_stall)
		else $error("input taken straight after the last byte");

endmodule

bind block_match_obfuscating_encoder bme_checker u_bme_checker (.*);

`default_nettype wire
